// File: hw/rtl/esf_pkg.sv
// ----------------------------------------------------------------------------
// esf_pkg
// shared types and constants of the event suppression filter
// ----------------------------------------------------------------------------
package esf_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 16;
	localparam int unsigned RATE_WINDOW_SECONDS = 60;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// verdict codes
	typedef enum logic [2:0] {
		VERDICT_PERMIT   = 3'd0,
		VERDICT_DEBOUNCE = 3'd1,
		VERDICT_COOLDOWN = 3'd2,
		VERDICT_GROUPING = 3'd3,
		VERDICT_RATE     = 3'd4,
		VERDICT_STALE    = 3'd5,
		VERDICT_ERROR    = 3'd6
	} verdict_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_WINDOW  = 3'd0,
		CFG_COOLDOWN_WINDOW  = 3'd1,
		CFG_GROUPING_WINDOW  = 3'd2,
		CFG_MAX_PER_MINUTE   = 3'd3,
		CFG_ROUTE_ENABLED    = 3'd4,
		CFG_CURRENT_REVISION = 3'd5
	} cfg_reg_t;

	// command codes
	typedef enum logic {
		CMD_CHECK  = 1'b0,
		CMD_RECORD = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  key_slot;
		logic [31:0] request_revision;
		logic [31:0] now_seconds;
		logic [63:0] event_tag;
	} item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] suppressed_total;
	} result_t;

endpackage

// File: hw/rtl/event_suppression_filter_unit.sv
// ----------------------------------------------------------------------------
// event_suppression_filter_unit
// per-key event throttle: debounce, cooldown, grouping and rate limit per slot
// ----------------------------------------------------------------------------
// a transaction accepted at an edge goes into the input register, then its
// verdict into the result register, which drives the result strobe on done
// throughput: one transaction per cycle, busy never rises; the slot table is
// written at the same edge as the result register, so the next item sees it
// the receiver cannot stall, results are strobed for exactly one cycle
// reset clears the slot table, config registers and strobe flags at once, no clearing pass
module event_suppression_filter_unit #(
	parameter int unsigned SLOT_COUNT = esf_pkg::SLOT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             start,
	output logic                             busy,
	input  esf_pkg::item_t                   item,
	// result channel
	output logic                             done,
	output esf_pkg::result_t                 result,
	// configuration channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [esf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [esf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// window test: a zero span or a zero start means inactive, time behind
	// the start counts as inside
	function automatic logic in_window(input logic [31:0] now_t,
			input logic [31:0] since, input logic [31:0] span);
		logic [31:0] diff;
		diff = now_t - since;
		if (span == '0 || since == '0) begin
			return 1'b0;
		end
		return (now_t < since) || (diff < span);
	endfunction

	function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a : b;
	endfunction

	// configuration registers
	logic [15:0] debounce_window_q;
	logic [15:0] cooldown_window_q;
	logic [15:0] grouping_window_q;
	logic [15:0] max_per_minute_q;
	logic        route_enabled_q;
	logic [31:0] current_revision_q;

	// input stage
	logic           valid_s1;
	esf_pkg::item_t item_s1;

	// slot table
	logic [31:0]           obs_q   [SLOT_COUNT];
	logic [31:0]           allow_q [SLOT_COUNT];
	logic [31:0]           rws_q   [SLOT_COUNT];
	logic [15:0]           rcnt_q  [SLOT_COUNT];
	logic [31:0]           group_q [SLOT_COUNT];
	logic [31:0]           sup_q   [SLOT_COUNT];
	logic [63:0]           tag_q   [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] tag_present_q;

	// output registers
	logic             done_q;
	esf_pkg::result_t result_q;

	// datapath signals of the item in stage one
	logic [IDX_W-1:0]  idx;
	logic              in_range;
	logic [31:0]       now_v;
	logic [31:0]       obs_r, allow_r, rws_r, group_r, sup_r;
	logic [15:0]       rcnt_r;
	logic [63:0]       tag_r;
	logic              tag_hit;
	logic [31:0]       eff_a, eff_b, eff;
	logic              rate_active;
	logic              upd;
	logic [31:0]       obs_nx, allow_nx, rws_nx, group_nx, sup_nx;
	logic [15:0]       rcnt_nx;
	esf_pkg::verdict_t verdict_nx;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// configuration writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_window_q  <= '0;
			cooldown_window_q  <= '0;
			grouping_window_q  <= '0;
			max_per_minute_q   <= '0;
			route_enabled_q    <= 1'b0;
			current_revision_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				esf_pkg::CFG_DEBOUNCE_WINDOW:  debounce_window_q  <= cfg_data[15:0];
				esf_pkg::CFG_COOLDOWN_WINDOW:  cooldown_window_q  <= cfg_data[15:0];
				esf_pkg::CFG_GROUPING_WINDOW:  grouping_window_q  <= cfg_data[15:0];
				esf_pkg::CFG_MAX_PER_MINUTE:   max_per_minute_q   <= cfg_data[15:0];
				esf_pkg::CFG_ROUTE_ENABLED:    route_enabled_q    <= cfg_data[0];
				esf_pkg::CFG_CURRENT_REVISION: current_revision_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// slot read
	assign idx      = IDX_W'(item_s1.key_slot);
	assign in_range = 32'(item_s1.key_slot) < SLOT_COUNT;
	assign now_v    = item_s1.now_seconds;
	assign obs_r    = obs_q[idx];
	assign allow_r  = allow_q[idx];
	assign rws_r    = rws_q[idx];
	assign rcnt_r   = rcnt_q[idx];
	assign group_r  = group_q[idx];
	assign sup_r    = sup_q[idx];
	assign tag_r    = tag_q[idx];
	assign tag_hit  = tag_present_q[idx] && (tag_r == item_s1.event_tag);

	// latest known time for a record, as a small max tree
	assign eff_a       = max32(now_v, obs_r);
	assign eff_b       = max32(allow_r, rws_r);
	assign eff         = max32(max32(eff_a, eff_b), group_r);
	assign rate_active = (rws_r != '0) &&
		((eff - rws_r) < 32'(esf_pkg::RATE_WINDOW_SECONDS));

	// verdict and slot update
	always_comb begin
		verdict_nx = esf_pkg::VERDICT_PERMIT;
		upd        = 1'b0;
		obs_nx     = obs_r;
		allow_nx   = allow_r;
		rws_nx     = rws_r;
		rcnt_nx    = rcnt_r;
		group_nx   = group_r;
		sup_nx     = sup_r;
		if (!in_range) begin
			verdict_nx = esf_pkg::VERDICT_ERROR;
		end else if (now_v == '0 || item_s1.request_revision == '0) begin
			verdict_nx = esf_pkg::VERDICT_ERROR;
		end else if (!route_enabled_q || item_s1.request_revision != current_revision_q) begin
			verdict_nx = esf_pkg::VERDICT_STALE;
		end else if (item_s1.cmd == esf_pkg::CMD_CHECK) begin
			priority if (in_window(now_v, obs_r, 32'(debounce_window_q))) begin
				verdict_nx = esf_pkg::VERDICT_DEBOUNCE;
			end else if (in_window(now_v, allow_r, 32'(cooldown_window_q))) begin
				verdict_nx = esf_pkg::VERDICT_COOLDOWN;
			end else if (in_window(now_v, group_r, 32'(grouping_window_q))) begin
				verdict_nx = esf_pkg::VERDICT_GROUPING;
			end else if (max_per_minute_q != '0 &&
					in_window(now_v, rws_r, 32'(esf_pkg::RATE_WINDOW_SECONDS)) &&
					rcnt_r >= max_per_minute_q) begin
				verdict_nx = esf_pkg::VERDICT_RATE;
			end else begin
				verdict_nx = esf_pkg::VERDICT_PERMIT;
			end
			if (verdict_nx != esf_pkg::VERDICT_PERMIT) begin
				upd    = 1'b1;
				obs_nx = max32(now_v, obs_r);
				if (sup_r != '1) begin
					sup_nx = sup_r + 32'd1;
				end
			end
		end else if (!tag_hit) begin
			// record of a new event
			upd      = 1'b1;
			obs_nx   = eff;
			allow_nx = eff;
			group_nx = (grouping_window_q != '0) ? eff : '0;
			if (max_per_minute_q != '0) begin
				if (!rate_active) begin
					rws_nx  = eff;
					rcnt_nx = 16'd1;
				end else if (rcnt_r != '1) begin
					rcnt_nx = rcnt_r + 16'd1;
				end
			end else begin
				rws_nx  = '0;
				rcnt_nx = '0;
			end
		end
	end

	// slot table write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				obs_q[i]   <= '0;
				allow_q[i] <= '0;
				rws_q[i]   <= '0;
				rcnt_q[i]  <= '0;
				group_q[i] <= '0;
				sup_q[i]   <= '0;
				tag_q[i]   <= '0;
			end
			tag_present_q <= '0;
		end else if (valid_s1 && upd) begin
			obs_q[idx]   <= obs_nx;
			allow_q[idx] <= allow_nx;
			rws_q[idx]   <= rws_nx;
			rcnt_q[idx]  <= rcnt_nx;
			group_q[idx] <= group_nx;
			sup_q[idx]   <= sup_nx;
			if (item_s1.cmd == esf_pkg::CMD_RECORD) begin
				tag_q[idx]         <= item_s1.event_tag;
				tag_present_q[idx] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.verdict          <= verdict_nx;
			result_q.suppressed_total <= in_range ? sup_nx : '0;
		end
	end

endmodule

// File: hw/rtl/esf_checker.sv
// ----------------------------------------------------------------------------
// esf_checker
// port level checks of the event suppression filter
// ----------------------------------------------------------------------------
module esf_checker #(
	parameter int unsigned SLOT_COUNT = esf_pkg::SLOT_COUNT_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input esf_pkg::item_t                 item,
	input logic                           done,
	input esf_pkg::result_t               result
);

	// every accepted transaction gives a result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction gave no result");

	// no result without an accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without transaction");

	// slot out of range gives error and a zero count
	a_bad_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(32'(item.key_slot) >= SLOT_COUNT, 2)) |->
		(result.verdict == esf_pkg::VERDICT_ERROR && result.suppressed_total == '0))
		else $error("out of range slot not flagged");

	// zero time or zero revision is an error
	a_zero_req: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(item.now_seconds == '0 || item.request_revision == '0, 2)) |->
		result.verdict == esf_pkg::VERDICT_ERROR)
		else $error("invalid request not flagged");

endmodule

bind event_suppression_filter_unit esf_checker #(.SLOT_COUNT(SLOT_COUNT)) u_esf_checker (.*);

// File: sim/event_suppression_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_suppression_filter_unit_tb
// self-checking bench: a scoreboard keeps its own copy of the slot table and
// the registers, predicts verdict and suppressed count for every accepted
// transaction and compares them in order with the strobed results
// ----------------------------------------------------------------------------
module event_suppression_filter_unit_tb;

	import esf_pkg::*;

	localparam int unsigned NUM_SLOTS = SLOT_COUNT_DEF;
	localparam int unsigned PHASES    = 7;
	localparam int unsigned PHASE_LEN = 250;
	localparam int unsigned BURST_LEN = 10;

	// ------------------------------------------------------------------------
	// scoreboard: throttle table mirror plus queue of predicted results
	// ------------------------------------------------------------------------
	class throttle_scoreboard;
		// registers
		logic [15:0] debounce_w;
		logic [15:0] cooldown_w;
		logic [15:0] grouping_w;
		logic [15:0] max_pm;
		logic        route_on;
		logic [31:0] cur_rev;
		// per-slot table
		logic [31:0] observed_t [NUM_SLOTS];
		logic [31:0] allowed_t  [NUM_SLOTS];
		logic [31:0] win_start  [NUM_SLOTS];
		logic [15:0] win_count  [NUM_SLOTS];
		logic [31:0] group_t    [NUM_SLOTS];
		logic [31:0] suppressed [NUM_SLOTS];
		logic [63:0] last_tag   [NUM_SLOTS];
		bit          tag_valid  [NUM_SLOTS];

		result_t pending_verdicts [$];
		int      mismatch_count;

		function new();
			debounce_w = '0;
			cooldown_w = '0;
			grouping_w = '0;
			max_pm     = '0;
			route_on   = 1'b0;
			cur_rev    = '0;
			mismatch_count = 0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				observed_t[i] = '0;
				allowed_t[i]  = '0;
				win_start[i]  = '0;
				win_count[i]  = '0;
				group_t[i]    = '0;
				suppressed[i] = '0;
				last_tag[i]   = '0;
				tag_valid[i]  = 1'b0;
			end
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] d);
			case (idx)
				CFG_DEBOUNCE_WINDOW:  debounce_w = d[15:0];
				CFG_COOLDOWN_WINDOW:  cooldown_w = d[15:0];
				CFG_GROUPING_WINDOW:  grouping_w = d[15:0];
				CFG_MAX_PER_MINUTE:   max_pm     = d[15:0];
				CFG_ROUTE_ENABLED:    route_on   = d[0];
				CFG_CURRENT_REVISION: cur_rev    = d;
				default: ;
			endcase
		endfunction

		// a stored time of zero means never; a time behind the stamp is inside
		function bit in_window(logic [31:0] now_s, logic [31:0] since, logic [31:0] span);
			if (span == 0 || since == 0)
				return 1'b0;
			return (now_s < since) || ((now_s - since) < span);
		endfunction

		// verdict and slot update for one transaction
		function result_t predict_verdict(item_t it);
			result_t     r;
			verdict_t    v;
			int unsigned s;
			logic [31:0] eff;
			bit          active;
			s = it.key_slot;
			r.suppressed_total = '0;
			if (s >= NUM_SLOTS) begin
				r.verdict = VERDICT_ERROR;
				return r;
			end
			if (it.now_seconds == 0 || it.request_revision == 0) begin
				v = VERDICT_ERROR;
			end else if (!route_on || it.request_revision != cur_rev) begin
				v = VERDICT_STALE;
			end else if (it.cmd == CMD_CHECK) begin
				if (in_window(it.now_seconds, observed_t[s], 32'(debounce_w)))
					v = VERDICT_DEBOUNCE;
				else if (in_window(it.now_seconds, allowed_t[s], 32'(cooldown_w)))
					v = VERDICT_COOLDOWN;
				else if (in_window(it.now_seconds, group_t[s], 32'(grouping_w)))
					v = VERDICT_GROUPING;
				else if (max_pm != 0 &&
						in_window(it.now_seconds, win_start[s], RATE_WINDOW_SECONDS) &&
						win_count[s] >= max_pm)
					v = VERDICT_RATE;
				else
					v = VERDICT_PERMIT;
				if (v != VERDICT_PERMIT) begin
					if (it.now_seconds > observed_t[s])
						observed_t[s] = it.now_seconds;
					if (suppressed[s] != 32'hFFFF_FFFF)
						suppressed[s] = suppressed[s] + 1;
				end
			end else begin
				v = VERDICT_PERMIT;
				// same tag as the one stored: nothing to do
				if (!(tag_valid[s] && last_tag[s] == it.event_tag)) begin
					eff = it.now_seconds;
					if (observed_t[s] > eff) eff = observed_t[s];
					if (allowed_t[s] > eff)  eff = allowed_t[s];
					if (win_start[s] > eff)  eff = win_start[s];
					if (group_t[s] > eff)    eff = group_t[s];
					observed_t[s] = eff;
					allowed_t[s]  = eff;
					group_t[s]    = (grouping_w != 0) ? eff : 32'd0;
					active = win_start[s] != 0 && (eff - win_start[s]) < RATE_WINDOW_SECONDS;
					if (max_pm != 0) begin
						if (!active) begin
							win_start[s] = eff;
							win_count[s] = 16'd1;
						end else if (win_count[s] != 16'hFFFF) begin
							win_count[s] = win_count[s] + 1;
						end
					end else begin
						win_start[s] = '0;
						win_count[s] = '0;
					end
					last_tag[s]  = it.event_tag;
					tag_valid[s] = 1'b1;
				end
			end
			r.verdict = v;
			r.suppressed_total = suppressed[s];
			return r;
		endfunction

		function void note_item(item_t it);
			pending_verdicts.push_back(predict_verdict(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%t result with no transaction waiting: verdict %0d total %0d",
						$realtime, got.verdict, got.suppressed_total);
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.verdict !== want.verdict ||
					got.suppressed_total !== want.suppressed_total) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%t mismatch: verdict exp %0d got %0d, total exp %0d got %0d",
						$realtime, want.verdict, got.verdict,
						want.suppressed_total, got.suppressed_total);
			end
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block under test
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  done;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	event_suppression_filter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	throttle_scoreboard sb = new();

	// stimulus state: running time, revision in use, recent tag per slot
	logic [31:0] stim_time;
	logic [31:0] stim_rev;
	logic [63:0] recent_tag [NUM_SLOTS];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("** event_suppression_filter_unit: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// monitor: everything sampled at the rising edge, before the edge updates
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// results first, they always belong to older transactions
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_item(item);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
		end
	end

	// ------------------------------------------------------------------------
	// drivers, always entered right after a rising edge
	// ------------------------------------------------------------------------

	// one item transaction; start stays high afterwards so back-to-back
	// items never lower and raise it in the same step
	task automatic send_item(item_t it, int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic push_item(cmd_t c, int unsigned slot, logic [31:0] rev,
			logic [31:0] t, logic [63:0] tag);
		item_t it;
		it.cmd              = c;
		it.key_slot         = 4'(slot);
		it.request_revision = rev;
		it.now_seconds      = t;
		it.event_tag        = tag;
		send_item(it, 0);
	endtask

	// stop issuing and let every outstanding result come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		// a margin after the last result
		repeat (4) @(posedge clk);
	endtask

	// write all six registers, only while the block is idle
	task automatic program_regs(logic [15:0] dbw, logic [15:0] cdw, logic [15:0] grw,
			logic [15:0] mpm, logic en, logic [31:0] rev);
		logic [31:0] vals [6];
		cfg_reg_t    regs [6];
		regs = '{CFG_DEBOUNCE_WINDOW, CFG_COOLDOWN_WINDOW, CFG_GROUPING_WINDOW,
			CFG_MAX_PER_MINUTE, CFG_ROUTE_ENABLED, CFG_CURRENT_REVISION};
		vals = '{32'(dbw), 32'(cdw), 32'(grw), 32'(mpm), 32'(en), rev};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		stim_rev = rev;
	endtask

	// mostly well-formed traffic on a few hot slots with a slowly moving
	// clock, plus errors, stale revisions and arbitrary times as noise
	function automatic item_t make_item();
		item_t       it;
		int unsigned roll;
		int unsigned slot;
		roll = $urandom_range(99);
		if (roll < 5)
			stim_time = stim_time - $urandom_range(100);
		else if (roll < 8)
			stim_time = stim_time + $urandom_range(200);
		else
			stim_time = stim_time + $urandom_range(8);
		slot = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(NUM_SLOTS - 1);
		it.cmd              = ($urandom_range(99) < 40) ? CMD_RECORD : CMD_CHECK;
		it.key_slot         = 4'(slot);
		it.request_revision = stim_rev;
		it.now_seconds      = stim_time;
		// repeating the last tag exercises the duplicate record path
		it.event_tag = ($urandom_range(99) < 25) ? recent_tag[slot] : {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 3)
			it.request_revision = '0;
		else if (roll < 6)
			it.now_seconds = '0;
		else if (roll < 10)
			it.request_revision = $urandom;
		else if (roll < 14)
			it.now_seconds = $urandom;
		if (it.cmd == CMD_RECORD)
			recent_tag[slot] = it.event_tag;
		return it;
	endfunction

	function automatic logic [15:0] pick_window();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [15:0] pick_rate();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] rev;
		int unsigned idle_pct;

		// every input known from time zero
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		stim_time = 32'd1;
		stim_rev  = 32'd1;
		for (int i = 0; i < NUM_SLOTS; i++)
			recent_tag[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// route disabled after reset: stale, but a zero revision is an error first
		push_item(CMD_CHECK, 0, 32'd1, 32'd1, 64'd0);
		push_item(CMD_CHECK, 0, 32'd0, 32'd1, 64'd0);
		drain();

		program_regs(16'd10, 16'd20, 16'd30, 16'd2, 1'b1, 32'd5);
		push_item(CMD_CHECK, 0, 32'd0, 32'd100, 64'd0);              // zero revision
		push_item(CMD_CHECK, 0, 32'd5, 32'd0, 64'd0);                // zero time
		push_item(CMD_CHECK, 0, 32'd6, 32'd100, 64'd0);              // wrong revision
		push_item(CMD_CHECK, 0, 32'd5, 32'd100, 64'd0);              // fresh slot permits
		push_item(CMD_RECORD, 0, 32'd5, 32'd100, 64'd0);             // tag zero, none stored yet
		push_item(CMD_RECORD, 0, 32'd5, 32'd100, 64'd0);             // duplicate tag, no-op
		push_item(CMD_CHECK, 0, 32'd5, 32'd105, 64'd0);              // debounce
		push_item(CMD_CHECK, 0, 32'd5, 32'd115, 64'd0);              // cooldown
		push_item(CMD_CHECK, 0, 32'd5, 32'd126, 64'd0);              // grouping
		push_item(CMD_CHECK, 0, 32'd5, 32'd50, 64'd0);               // time behind stamp
		push_item(CMD_RECORD, 0, 32'd5, 32'd90, 64'hFFFF_FFFF_FFFF_FFFF); // stamps at later time
		push_item(CMD_CHECK, 15, 32'd5, 32'hFFFF_FFFF, 64'd0);
		push_item(CMD_RECORD, 15, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		push_item(CMD_CHECK, 15, 32'd5, 32'hFFFF_FFFF, 64'd0);
		drain();

		// route switched off by a write
		program_regs(16'd0, 16'd0, 16'd0, 16'd2, 1'b0, 32'hFFFF_FFFF);
		push_item(CMD_CHECK, 1, 32'hFFFF_FFFF, 32'd1000, 64'd0);
		drain();

		// rate limit with every other window off
		program_regs(16'd0, 16'd0, 16'd0, 16'd2, 1'b1, 32'hFFFF_FFFF);
		push_item(CMD_RECORD, 1, 32'hFFFF_FFFF, 32'd1000, 64'h0123_4567_89AB_CDEF);
		push_item(CMD_RECORD, 1, 32'hFFFF_FFFF, 32'd1001, 64'hFEDC_BA98_7654_3210);
		push_item(CMD_CHECK, 1, 32'hFFFF_FFFF, 32'd1002, 64'd0);     // over the limit
		push_item(CMD_CHECK, 1, 32'hFFFF_FFFF, 32'd1060, 64'd0);     // window expired
		push_item(CMD_RECORD, 1, 32'hFFFF_FFFF, 32'd1059, 64'd7);
		drain();

		// rate limit off: a record clears the slot's window
		program_regs(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'hFFFF_FFFF);
		push_item(CMD_RECORD, 1, 32'hFFFF_FFFF, 32'd2000, 64'd8);
		push_item(CMD_CHECK, 1, 32'hFFFF_FFFF, 32'd2001, 64'd0);
		drain();

		// ---- random phases ----
		for (int ph = 0; ph < PHASES; ph++) begin
			// sender idling: light, then heavy, then none
			idle_pct = (ph < 3) ? 20 : (ph < 5) ? 77 : 0;
			rev = $urandom;
			if (rev == 0)
				rev = 32'd1;
			case (ph)
				0:       program_regs(16'd0, 16'd0, 16'd0, pick_rate(), 1'b1, rev);
				1:       program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
						32'hFFFF_FFFF);
				2:       program_regs(pick_window(), pick_window(), pick_window(),
						pick_rate(), 1'b1, 32'd1);
				default: program_regs(pick_window(), pick_window(), pick_window(),
						pick_rate(), 1'b1, rev);
			endcase
			// start times across the whole range, small values and near the wrap
			case (ph % 3)
				0:       stim_time = $urandom;
				1:       stim_time = $urandom_range(1, 1000);
				default: stim_time = 32'hFFFF_FF00 + $urandom_range(0, 200);
			endcase
			for (int n = 0; n < PHASE_LEN; n++)
				send_item(make_item(), idle_pct);
			drain();
		end

		// ---- a burst of records on one slot against a small rate limit ----
		program_regs(16'd0, 16'd0, 16'd0, 16'd8, 1'b1, 32'd77);
		for (int n = 0; n < BURST_LEN; n++)
			push_item(CMD_RECORD, 9, 32'd77, 32'd5000, 64'(n + 1));
		push_item(CMD_CHECK, 9, 32'd77, 32'd5000, 64'd0);
		push_item(CMD_CHECK, 9, 32'd77, 32'd5059, 64'd0);
		push_item(CMD_CHECK, 9, 32'd77, 32'd5060, 64'd0);
		push_item(CMD_RECORD, 9, 32'd77, 32'd5060, 64'd0);
		push_item(CMD_CHECK, 9, 32'd77, 32'd5061, 64'd0);
		drain();

		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("** event_suppression_filter_unit: PASSED **");
		else
			$display("** event_suppression_filter_unit: FAILED **");
		$finish;
	end

endmodule
